[rtl/cdtd_pkg.sv]
package cdtd_pkg;

  // field widths of the command and result words
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TIDX_W    = 10;
  localparam int unsigned EDGE_W    = 12;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned COUNT_W   = 11;

  // default geometry
  localparam int unsigned MAX_COLS_DEF = 32;
  localparam int unsigned MAX_ROWS_DEF = 32;
  localparam int unsigned TILE_W_DEF   = 64;
  localparam int unsigned TILE_H_DEF   = 64;

  localparam logic [CFG_W-1:0]   GRID_RESET = 12'd2048;
  localparam logic [PHASE_W-1:0] NUM_PHASES = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK       = 3'd0,
    CMD_FORCE      = 3'd1,
    CMD_START      = 3'd2,
    CMD_NEXT_TILE  = 3'd3,
    CMD_NEXT_PHASE = 3'd4,
    CMD_LOOKUP     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

endpackage

[rtl/checkerboard_dirty_tile_dispatcher_top.sv]
// a command passes the input register and then the result register, which gives its
// result word with done_o high; throughput: one command per cycle while not busy;
// every command completes in one pass through the logic between the two registers,
// the dirty bits being flip-flop vectors
// reset: asynchronous, active low; clears all dirty bits, phase and cursor, sets both
// grid registers to 2048; busy_o stays high for the first cycle after release
// the receiver cannot stall: done_o marks each result word for exactly one cycle
module checkerboard_dirty_tile_dispatcher_top #(
  parameter int unsigned MAX_COLS = cdtd_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = cdtd_pkg::MAX_ROWS_DEF,
  parameter int unsigned TILE_W   = cdtd_pkg::TILE_W_DEF,
  parameter int unsigned TILE_H   = cdtd_pkg::TILE_H_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [cdtd_pkg::CMD_W-1:0]        cmd_i,
  input  logic [cdtd_pkg::COORD_W-1:0]      grid_x_i,
  input  logic [cdtd_pkg::COORD_W-1:0]      grid_y_i,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [cdtd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cdtd_pkg::CFG_W-1:0]        cfg_wdata_i,
  // result channel
  output logic                              done_o,
  output logic [cdtd_pkg::STATUS_W-1:0]     status_o,
  output logic [cdtd_pkg::TIDX_W-1:0]       tile_index_o,
  output logic [cdtd_pkg::COORD_W-1:0]      tile_left_o,
  output logic [cdtd_pkg::COORD_W-1:0]      tile_top_o,
  output logic [cdtd_pkg::EDGE_W-1:0]       tile_right_o,
  output logic [cdtd_pkg::EDGE_W-1:0]       tile_bottom_o,
  output logic                              tile_dirty_o,
  output logic                              phase_open_o,
  output logic [cdtd_pkg::PHASE_W-1:0]      phase_now_o,
  output logic [cdtd_pkg::COUNT_W-1:0]      tile_count_o
);
  import cdtd_pkg::*;

  // geometry derived from the parameters
  localparam int unsigned SLOTS = MAX_COLS * MAX_ROWS;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned COL_W = $clog2(MAX_COLS + 1);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned LIM_W = MAX_COLS * TILE_W;
  localparam int unsigned LIM_H = MAX_ROWS * TILE_H;

  // clamp a grid size to 1 .. limit
  function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int unsigned lim);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > lim) begin
      r = CFG_W'(lim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] cols_of(logic [CFG_W-1:0] w);
    return COL_W'((32'(w) + TILE_W - 1) / TILE_W);
  endfunction

  function automatic logic [ROW_W-1:0] rows_of(logic [CFG_W-1:0] h);
    return ROW_W'((32'(h) + TILE_H - 1) / TILE_H);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration: effective sizes and tile counts are worked out at write time
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] eff_w_q, eff_h_q;
  logic [COL_W-1:0] cols_q;
  logic [ROW_W-1:0] rows_q;
  logic             cfg_hit;

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == CFG_GRID_WIDTH || cfg_idx_i == CFG_GRID_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= clamp_size(GRID_RESET, LIM_W);
      eff_h_q <= clamp_size(GRID_RESET, LIM_H);
      cols_q  <= cols_of(clamp_size(GRID_RESET, LIM_W));
      rows_q  <= rows_of(clamp_size(GRID_RESET, LIM_H));
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GRID_WIDTH) begin
        eff_w_q <= clamp_size(cfg_wdata_i, LIM_W);
        cols_q  <= cols_of(clamp_size(cfg_wdata_i, LIM_W));
      end else if (cfg_idx_i == CFG_GRID_HEIGHT) begin
        eff_h_q <= clamp_size(cfg_wdata_i, LIM_H);
        rows_q  <= rows_of(clamp_size(cfg_wdata_i, LIM_H));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic               busy_q;
  logic               in_accept;
  logic               in_valid_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [COORD_W-1:0] x_q, y_q;

  assign busy_o    = busy_q;
  assign in_accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      in_valid_q <= 1'b0;
    end else begin
      busy_q     <= 1'b0;
      in_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_i;
      x_q   <= grid_x_i;
      y_q   <= grid_y_i;
    end
  end

  // ---------------------------------------------------------------------------
  // tile state
  // ---------------------------------------------------------------------------
  logic [SLOTS-1:0]   dirty_now_q, dirty_now_d;
  logic [SLOTS-1:0]   dirty_next_q, dirty_next_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [ROW_W-1:0]   cur_row_q, cur_row_d;

  // ---------------------------------------------------------------------------
  // command decode and tile geometry
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   count;
  logic [SLOTS-1:0]   force_mask;
  logic               outside;
  logic [COL_W:0]     nt_col, nt_col_inc;
  logic [ROW_W:0]     nt_row;
  logic [COL_W-1:0]   col_inc;
  logic               nt_none;
  logic               by_coord;
  logic [COL_W-1:0]   tile_c;
  logic [ROW_W-1:0]   tile_r;
  logic [CNT_W-1:0]   idx;
  logic [31:0]        left_full, top_full, right_full, bottom_full;
  logic [EDGE_W-1:0]  right_clip, bottom_clip;
  logic               report;
  logic [STATUS_W-1:0] status_d;
  logic               dirty_bit;

  assign count = CNT_W'(cols_q) * CNT_W'(rows_q);

  // force recheck covers the tiles below the tile count
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      force_mask[i] = CNT_W'(i) < count;
    end
  end

  assign outside = ({1'b0, x_q} >= eff_w_q) || ({1'b0, y_q} >= eff_h_q);

  // cursor position in tiles for the current parity phase
  assign nt_col     = {cur_col_q, phase_q[0]};
  assign nt_row     = {cur_row_q, phase_q[1]};
  assign col_inc    = cur_col_q + COL_W'(1);
  assign nt_col_inc = {col_inc, phase_q[0]};
  assign nt_none    = (phase_q >= NUM_PHASES) || (nt_col >= {1'b0, cols_q}) ||
                      (nt_row >= {1'b0, rows_q});

  assign by_coord = (cmd_q == CMD_MARK) || (cmd_q == CMD_LOOKUP);
  assign tile_c   = by_coord ? COL_W'(x_q / TILE_W) : nt_col[COL_W-1:0];
  assign tile_r   = by_coord ? ROW_W'(y_q / TILE_H) : nt_row[ROW_W-1:0];
  assign idx      = CNT_W'(tile_r) * CNT_W'(cols_q) + CNT_W'(tile_c);

  assign left_full   = 32'(tile_c) * TILE_W;
  assign top_full    = 32'(tile_r) * TILE_H;
  assign right_full  = left_full + TILE_W;
  assign bottom_full = top_full + TILE_H;
  assign right_clip  = (right_full > 32'(eff_w_q)) ? eff_w_q : EDGE_W'(right_full);
  assign bottom_clip = (bottom_full > 32'(eff_h_q)) ? eff_h_q : EDGE_W'(bottom_full);

  // a mark reports the tile after it is set
  assign dirty_bit = (cmd_q == CMD_MARK) ? 1'b1 : dirty_now_q[idx[IDX_W-1:0]];

  always_comb begin
    dirty_now_d  = dirty_now_q;
    dirty_next_d = dirty_next_q;
    phase_d      = phase_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    report       = 1'b0;
    status_d     = ST_OK;
    if (cfg_hit) begin
      // a write to either grid register restarts the dispatcher
      dirty_now_d  = '0;
      dirty_next_d = '0;
      phase_d      = '0;
      cur_col_d    = '0;
      cur_row_d    = '0;
    end else if (in_valid_q) begin
      unique case (cmd_q)
        CMD_MARK: begin
          if (outside) begin
            status_d = ST_OUTSIDE;
          end else begin
            report                         = 1'b1;
            dirty_now_d[idx[IDX_W-1:0]]    = 1'b1;
            dirty_next_d[idx[IDX_W-1:0]]   = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          if (outside) begin
            status_d = ST_OUTSIDE;
          end else begin
            report = 1'b1;
          end
        end
        CMD_FORCE: begin
          dirty_now_d  = dirty_now_q | force_mask;
          dirty_next_d = dirty_next_q | force_mask;
        end
        CMD_START: begin
          dirty_now_d  = dirty_next_q;
          dirty_next_d = '0;
          phase_d      = '0;
          cur_col_d    = '0;
          cur_row_d    = '0;
        end
        CMD_NEXT_TILE: begin
          if (nt_none) begin
            status_d = ST_NONE;
          end else begin
            report = 1'b1;
            if (nt_col_inc >= {1'b0, cols_q}) begin
              cur_col_d = '0;
              cur_row_d = cur_row_q + ROW_W'(1);
            end else begin
              cur_col_d = col_inc;
            end
          end
        end
        CMD_NEXT_PHASE: begin
          cur_col_d = '0;
          cur_row_d = '0;
          if (phase_q < NUM_PHASES) begin
            phase_d = phase_q + PHASE_W'(1);
          end
          if (phase_d >= NUM_PHASES) begin
            status_d = ST_NONE;
          end
        end
        default: begin
          // unused codes leave everything alone
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_now_q  <= '0;
      dirty_next_q <= '0;
      phase_q      <= '0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
    end else begin
      dirty_now_q  <= dirty_now_d;
      dirty_next_q <= dirty_next_d;
      phase_q      <= phase_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      status_o      <= status_d;
      tile_index_o  <= report ? TIDX_W'(idx) : '0;
      tile_left_o   <= report ? COORD_W'(left_full) : '0;
      tile_top_o    <= report ? COORD_W'(top_full) : '0;
      tile_right_o  <= report ? right_clip : '0;
      tile_bottom_o <= report ? bottom_clip : '0;
      tile_dirty_o  <= report & dirty_bit;
      phase_open_o  <= phase_d < NUM_PHASES;
      phase_now_o   <= phase_d;
      tile_count_o  <= COUNT_W'(count);
    end
  end

  assign done_o = done_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_accept, 2))
    else $error("result word without an accepted command");

  a_phase_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= NUM_PHASES)
    else $error("phase counter past its limit");

  a_next_within_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dirty_next_q & ~dirty_now_q) == '0)
    else $error("next dirty bit set without current dirty bit");

  a_no_tile_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> tile_index_o == '0 && tile_right_o == '0 &&
                                    tile_dirty_o == 1'b0)
    else $error("tile fields reported with a failing status");

  a_cursor_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && cmd_q == CMD_NEXT_TILE && !nt_none |-> idx < count)
    else $error("dispatched tile beyond tile count");

endmodule

[sim/tile_dispatch_checker.sv]
`timescale 1ns / 1ps
module tile_dispatch_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [cdtd_pkg::CMD_W-1:0]     cmd_i,
  input  logic [cdtd_pkg::COORD_W-1:0]   grid_x_i,
  input  logic [cdtd_pkg::COORD_W-1:0]   grid_y_i,
  input  logic                           cfg_we_i,
  input  logic [cdtd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cdtd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           done_i,
  input  logic [cdtd_pkg::STATUS_W-1:0]  status_i,
  input  logic [cdtd_pkg::TIDX_W-1:0]    tile_index_i,
  input  logic [cdtd_pkg::COORD_W-1:0]   tile_left_i,
  input  logic [cdtd_pkg::COORD_W-1:0]   tile_top_i,
  input  logic [cdtd_pkg::EDGE_W-1:0]    tile_right_i,
  input  logic [cdtd_pkg::EDGE_W-1:0]    tile_bottom_i,
  input  logic                           tile_dirty_i,
  input  logic                           phase_open_i,
  input  logic [cdtd_pkg::PHASE_W-1:0]   phase_now_i,
  input  logic [cdtd_pkg::COUNT_W-1:0]   tile_count_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o
);
  import cdtd_pkg::*;

  localparam int unsigned TW          = TILE_W_DEF;
  localparam int unsigned TH          = TILE_H_DEF;
  localparam int unsigned SLOTS       = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam int unsigned W_LIMIT     = MAX_COLS_DEF * TILE_W_DEF;
  localparam int unsigned H_LIMIT     = MAX_ROWS_DEF * TILE_H_DEF;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIDX_W-1:0]   tile_index;
    logic [COORD_W-1:0]  tile_left;
    logic [COORD_W-1:0]  tile_top;
    logic [EDGE_W-1:0]   tile_right;
    logic [EDGE_W-1:0]   tile_bottom;
    logic                tile_dirty;
    logic                phase_open;
    logic [PHASE_W-1:0]  phase_now;
    logic [COUNT_W-1:0]  tile_count;
  } tile_word_t;

  // own copy of the dispatcher state
  logic [CFG_W-1:0]   width_q;
  logic [CFG_W-1:0]   height_q;
  logic [SLOTS-1:0]   dirty_now_q;
  logic [SLOTS-1:0]   dirty_next_q;
  logic [PHASE_W-1:0] phase_q;
  logic [5:0]         cur_col_q;
  logic [5:0]         cur_row_q;

  tile_word_t awaited_words[$];
  tile_word_t oldest_w;
  tile_word_t next_w;

  function automatic tile_word_t tile_fields(int unsigned c, int unsigned r,
                                             int unsigned cols, int unsigned ew,
                                             int unsigned eh);
    tile_word_t  t;
    int unsigned idx;
    int unsigned right;
    int unsigned bottom;
    t      = '0;
    idx    = r * cols + c;
    right  = c * TW + TW;
    bottom = r * TH + TH;
    if (right > ew) right = ew;
    if (bottom > eh) bottom = eh;
    t.status      = ST_OK;
    t.tile_index  = idx[TIDX_W-1:0];
    t.tile_left   = COORD_W'(c * TW);
    t.tile_top    = COORD_W'(r * TH);
    t.tile_right  = right[EDGE_W-1:0];
    t.tile_bottom = bottom[EDGE_W-1:0];
    t.tile_dirty  = (idx < SLOTS) ? dirty_now_q[idx] : 1'b0;
    return t;
  endfunction

  task automatic predict_dispatch(input logic [CMD_W-1:0] cmd,
                                  input logic [COORD_W-1:0] gx,
                                  input logic [COORD_W-1:0] gy,
                                  output tile_word_t w);
    int unsigned ew;
    int unsigned eh;
    int unsigned cols;
    int unsigned rows;
    int unsigned count;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    ew    = (width_q == '0) ? 1 : ((width_q > W_LIMIT) ? W_LIMIT : width_q);
    eh    = (height_q == '0) ? 1 : ((height_q > H_LIMIT) ? H_LIMIT : height_q);
    cols  = (ew + TW - 1) / TW;
    rows  = (eh + TH - 1) / TH;
    count = cols * rows;
    w     = '0;
    case (cmd)
      CMD_MARK, CMD_LOOKUP: begin
        if (gx >= ew || gy >= eh) begin
          w.status = ST_OUTSIDE;
        end else begin
          c   = gx / TW;
          r   = gy / TH;
          idx = r * cols + c;
          if (cmd == CMD_MARK && idx < SLOTS) begin
            dirty_now_q[idx]  = 1'b1;
            dirty_next_q[idx] = 1'b1;
          end
          w = tile_fields(c, r, cols, ew, eh);
        end
      end
      CMD_FORCE: begin
        for (int unsigned i = 0; i < count && i < SLOTS; i++) begin
          dirty_now_q[i]  = 1'b1;
          dirty_next_q[i] = 1'b1;
        end
      end
      CMD_START: begin
        dirty_now_q  = dirty_next_q;
        dirty_next_q = '0;
        phase_q      = '0;
        cur_col_q    = '0;
        cur_row_q    = '0;
      end
      CMD_NEXT_TILE: begin
        if (phase_q >= NUM_PHASES) begin
          w.status = ST_NONE;
        end else begin
          c = 2 * cur_col_q + phase_q[0];
          r = 2 * cur_row_q + phase_q[1];
          if (c >= cols || r >= rows) begin
            w.status = ST_NONE;
          end else begin
            w         = tile_fields(c, r, cols, ew, eh);
            cur_col_q = cur_col_q + 1'b1;
            if (2 * cur_col_q + phase_q[0] >= cols) begin
              cur_col_q = '0;
              cur_row_q = cur_row_q + 1'b1;
            end
          end
        end
      end
      CMD_NEXT_PHASE: begin
        cur_col_q = '0;
        cur_row_q = '0;
        if (phase_q < NUM_PHASES) phase_q = phase_q + 1'b1;
        w.status = (phase_q < NUM_PHASES) ? ST_OK : ST_NONE;
      end
      default: begin
      end
    endcase
    w.phase_open = (phase_q < NUM_PHASES);
    w.phase_now  = phase_q;
    w.tile_count = count[COUNT_W-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      = GRID_RESET;
      height_q     = GRID_RESET;
      dirty_now_q  = '0;
      dirty_next_q = '0;
      phase_q      = '0;
      cur_col_q    = '0;
      cur_row_q    = '0;
      awaited_words.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      // a write to either grid register restarts the whole state
      if (cfg_we_i && (cfg_idx_i == CFG_GRID_WIDTH || cfg_idx_i == CFG_GRID_HEIGHT)) begin
        if (cfg_idx_i == CFG_GRID_WIDTH) width_q = cfg_wdata_i;
        else height_q = cfg_wdata_i;
        dirty_now_q  = '0;
        dirty_next_q = '0;
        phase_q      = '0;
        cur_col_q    = '0;
        cur_row_q    = '0;
      end
      if (done_i) begin
        if (awaited_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: result word with none awaited: status %0d index %0d",
                     $realtime, status_i, tile_index_i);
        end else begin
          oldest_w = awaited_words.pop_front();
          checked_o++;
          if (oldest_w.status !== status_i || oldest_w.tile_index !== tile_index_i ||
              oldest_w.tile_left !== tile_left_i || oldest_w.tile_top !== tile_top_i ||
              oldest_w.tile_right !== tile_right_i ||
              oldest_w.tile_bottom !== tile_bottom_i ||
              oldest_w.tile_dirty !== tile_dirty_i ||
              oldest_w.phase_open !== phase_open_i ||
              oldest_w.phase_now !== phase_now_i ||
              oldest_w.tile_count !== tile_count_i) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS) begin
              $display("%0t: expected st %0d idx %0d l %0d t %0d r %0d b %0d d %0d po %0d ph %0d n %0d",
                       $realtime, oldest_w.status, oldest_w.tile_index, oldest_w.tile_left,
                       oldest_w.tile_top, oldest_w.tile_right, oldest_w.tile_bottom,
                       oldest_w.tile_dirty, oldest_w.phase_open, oldest_w.phase_now,
                       oldest_w.tile_count);
              $display("%0t: actual   st %0d idx %0d l %0d t %0d r %0d b %0d d %0d po %0d ph %0d n %0d",
                       $realtime, status_i, tile_index_i, tile_left_i, tile_top_i,
                       tile_right_i, tile_bottom_i, tile_dirty_i, phase_open_i,
                       phase_now_i, tile_count_i);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_dispatch(cmd_i, grid_x_i, grid_y_i, next_w);
        awaited_words = {awaited_words, next_w};
      end
      pending_o = awaited_words.size();
    end
  end

endmodule

[sim/checkerboard_dirty_tile_dispatcher_top_test.sv]
`timescale 1ns / 1ps
module checkerboard_dirty_tile_dispatcher_top_test;
  import cdtd_pkg::*;

  // codes that the block treats as spare
  localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int unsigned TW           = TILE_W_DEF;
  localparam int unsigned TH           = TILE_H_DEF;
  localparam int unsigned W_LIMIT      = MAX_COLS_DEF * TILE_W_DEF;
  localparam int unsigned H_LIMIT      = MAX_ROWS_DEF * TILE_H_DEF;
  localparam int unsigned PLAN_LEN     = 9;
  localparam int unsigned PER_SETTING  = 150;
  // last stretch of the run goes without sender gaps
  localparam int unsigned TAIL_FROM    = 1230;
  // result word leaves two registers after acceptance, so DRAIN_CYCLES is ample
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [CMD_W-1:0]     cmd_i;
  logic [COORD_W-1:0]   grid_x_i;
  logic [COORD_W-1:0]   grid_y_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic [TIDX_W-1:0]    tile_index_o;
  logic [COORD_W-1:0]   tile_left_o;
  logic [COORD_W-1:0]   tile_top_o;
  logic [EDGE_W-1:0]    tile_right_o;
  logic [EDGE_W-1:0]    tile_bottom_o;
  logic                 tile_dirty_o;
  logic                 phase_open_o;
  logic [PHASE_W-1:0]   phase_now_o;
  logic [COUNT_W-1:0]   tile_count_o;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned checked_words;

  // stimulus bookkeeping: the grid as the stimulus sees it
  int unsigned items_sent;
  int unsigned idle_odds;
  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned cur_cols;
  int unsigned cur_rows;
  logic [CFG_W-1:0] width_plan  [PLAN_LEN];
  logic [CFG_W-1:0] height_plan [PLAN_LEN];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  checkerboard_dirty_tile_dispatcher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .grid_x_i      (grid_x_i),
    .grid_y_i      (grid_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .tile_index_o  (tile_index_o),
    .tile_left_o   (tile_left_o),
    .tile_top_o    (tile_top_o),
    .tile_right_o  (tile_right_o),
    .tile_bottom_o (tile_bottom_o),
    .tile_dirty_o  (tile_dirty_o),
    .phase_open_o  (phase_open_o),
    .phase_now_o   (phase_now_o),
    .tile_count_o  (tile_count_o)
  );

  // checker sits beside the block and watches both channels and the register port
  tile_dispatch_checker u_word_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .cmd_i         (cmd_i),
    .grid_x_i      (grid_x_i),
    .grid_y_i      (grid_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .tile_index_i  (tile_index_o),
    .tile_left_i   (tile_left_o),
    .tile_top_i    (tile_top_o),
    .tile_right_i  (tile_right_o),
    .tile_bottom_i (tile_bottom_o),
    .tile_dirty_i  (tile_dirty_o),
    .phase_open_i  (phase_open_o),
    .phase_now_i   (phase_now_o),
    .tile_count_i  (tile_count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words),
    .checked_o     (checked_words)
  );

  // watchdog: ends the run once nothing has moved on either channel for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one command word; holds start until the block takes it, then maybe a short gap
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] gx,
                           input logic [COORD_W-1:0] gy);
    start_i  <= 1'b1;
    cmd_i    <= cmd;
    grid_x_i <= gx;
    grid_y_i <= gy;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    if (items_sent < TAIL_FROM && $urandom_range(0, 9) < idle_odds) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // drop start, let every awaited word come back, then the spare drain cycles
  task automatic settle();
    start_i <= 1'b0;
    while (pending_words != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write; the extra wait keeps write enable to one assignment per step
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    int unsigned clamped;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    clamped = (data == '0) ? 1 : data;
    if (idx == CFG_GRID_WIDTH) begin
      cur_w    = (clamped > W_LIMIT) ? W_LIMIT : clamped;
      cur_cols = (cur_w + TW - 1) / TW;
    end else if (idx == CFG_GRID_HEIGHT) begin
      cur_h    = (clamped > H_LIMIT) ? H_LIMIT : clamped;
      cur_rows = (cur_h + TH - 1) / TH;
    end
  endtask

  // coordinate: mostly inside, some on the border, some anywhere in the field
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned extent);
    int unsigned mode;
    int unsigned v;
    mode = $urandom_range(0, 9);
    if (mode < 5) v = $urandom_range(0, extent - 1);
    else if (mode < 7) v = extent - 1 + $urandom_range(0, 1);
    else v = $urandom_range(0, (1 << COORD_W) - 1);
    if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
    return v[COORD_W-1:0];
  endfunction

  // loose mix of every command, spare codes included
  task automatic random_word();
    int unsigned pick;
    logic [CMD_W-1:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 25) c = CMD_MARK;
    else if (pick < 40) c = CMD_LOOKUP;
    else if (pick < 62) c = CMD_NEXT_TILE;
    else if (pick < 74) c = CMD_NEXT_PHASE;
    else if (pick < 84) c = CMD_START;
    else if (pick < 90) c = CMD_FORCE;
    else if (pick < 95) c = CMD_SPARE_LO;
    else c = CMD_SPARE_HI;
    send_word(c, pick_coord(cur_w), pick_coord(cur_h));
  endtask

  // well-formed cycle: start, walk each parity phase one past its end, max 40
  task automatic sweep_cycle();
    int unsigned per_phase;
    int unsigned n;
    send_word(CMD_START, pick_coord(cur_w), pick_coord(cur_h));
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      per_phase = ((cur_cols + 1 - (p & 1)) / 2) * ((cur_rows + 1 - (p >> 1)) / 2);
      n = per_phase + 1;
      if (n > 40) n = $urandom_range(5, 40);
      for (int unsigned k = 0; k < n; k++) begin
        // sprinkle random commands between tiles so dirty bits vary
        if ($urandom_range(0, 4) == 0) random_word();
        send_word(CMD_NEXT_TILE, pick_coord(cur_w), pick_coord(cur_h));
      end
      send_word(CMD_NEXT_PHASE, pick_coord(cur_w), pick_coord(cur_h));
    end
    // past the last phase: saturation and no tile left
    if ($urandom_range(0, 1) == 1) begin
      send_word(CMD_NEXT_PHASE, pick_coord(cur_w), pick_coord(cur_h));
      send_word(CMD_NEXT_TILE, pick_coord(cur_w), pick_coord(cur_h));
    end
  endtask

  initial begin : stimulus
    int unsigned quota;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    cmd_i       <= CMD_MARK;
    grid_x_i    <= '0;
    grid_y_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_GRID_WIDTH;
    cfg_wdata_i <= '0;
    items_sent  = 0;
    idle_odds   = 2;
    cur_w       = W_LIMIT;
    cur_h       = H_LIMIT;
    cur_cols    = MAX_COLS_DEF;
    cur_rows    = MAX_ROWS_DEF;
    // extremes and clamps first, odd sizes after, one random grid last
    width_plan  = '{12'd2048, 12'd1, 12'd0, 12'd100, 12'd4095, 12'd300, 12'd65, 12'd448,
                    12'd0};
    height_plan = '{12'd2048, 12'd1, 12'd4095, 12'd70, 12'd0, 12'd200, 12'd129, 12'd512,
                     12'd0};
    width_plan[PLAN_LEN-1]  = CFG_W'($urandom_range(1, 700));
    height_plan[PLAN_LEN-1] = CFG_W'($urandom_range(1, 700));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the reset grid: far corners, marks carried over a start
    send_word(CMD_MARK, 11'd0, 11'd0);
    send_word(CMD_MARK, 11'd2047, 11'd2047);
    send_word(CMD_LOOKUP, 11'd2047, 11'd0);
    send_word(CMD_LOOKUP, 11'd0, 11'd0);
    send_word(CMD_NEXT_TILE, 11'd0, 11'd0);
    send_word(CMD_NEXT_TILE, 11'd0, 11'd0);
    send_word(CMD_START, 11'd0, 11'd0);
    send_word(CMD_NEXT_TILE, 11'd0, 11'd0);
    // phase runs out and then saturates
    repeat (5) send_word(CMD_NEXT_PHASE, 11'd0, 11'd0);
    send_word(CMD_NEXT_TILE, 11'd0, 11'd0);
    send_word(CMD_FORCE, 11'd0, 11'd0);
    send_word(CMD_LOOKUP, 11'd1000, 11'd1500);
    send_word(CMD_SPARE_LO, 11'd2047, 11'd0);
    send_word(CMD_SPARE_HI, 11'd0, 11'd2047);
    // writes to unused indexes leave the dirty bits alone
    settle();
    write_register(CFG_SPARE_LO, 12'd4095);
    write_register(CFG_SPARE_HI, 12'd0);
    send_word(CMD_LOOKUP, 11'd2047, 11'd2047);
    // small grid: coordinates just outside, clipped corner tile, empty phase tail
    settle();
    write_register(CFG_GRID_WIDTH, 12'd100);
    write_register(CFG_GRID_HEIGHT, 12'd70);
    send_word(CMD_MARK, 11'd100, 11'd5);
    send_word(CMD_LOOKUP, 11'd5, 11'd70);
    send_word(CMD_MARK, 11'd99, 11'd69);
    send_word(CMD_START, 11'd0, 11'd0);
    send_word(CMD_NEXT_PHASE, 11'd0, 11'd0);
    send_word(CMD_NEXT_TILE, 11'd0, 11'd0);
    send_word(CMD_NEXT_TILE, 11'd0, 11'd0);

    // random part, one batch per grid setting
    for (int unsigned s = 0; s < PLAN_LEN; s++) begin
      settle();
      write_register(CFG_GRID_WIDTH, width_plan[s]);
      write_register(CFG_GRID_HEIGHT, height_plan[s]);
      // one setting runs with no sender gaps at all
      idle_odds = (s == 4) ? 0 : $urandom_range(1, 4);
      quota = items_sent + PER_SETTING;
      while (items_sent < quota) begin
        if (cur_cols * cur_rows <= 121 && $urandom_range(0, 2) != 0) sweep_cycle();
        else repeat (8) random_word();
      end
    end

    settle();
    $display("%0d command words over %0d grid settings, %0d result words checked",
             items_sent, PLAN_LEN + 2, checked_words);
    if (fail_count == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cdtd_pkg.sv
rtl/checkerboard_dirty_tile_dispatcher_top.sv
sim/tile_dispatch_checker.sv
sim/checkerboard_dirty_tile_dispatcher_top_test.sv
